// File: src/pcm_silence_keepalive_patcher_macros.svh
// Assertion macros used by the checker file.
`ifndef PCM_SILENCE_KEEPALIVE_PATCHER_MACROS_SVH
`define PCM_SILENCE_KEEPALIVE_PATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSKP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pskp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSKP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pskp assertion failed");

`endif

// File: src/pskp_pkg.sv
package pskp_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS + 1);
    localparam int SEEN_W       = $clog2(2 * MAX_CHANNELS + 1);
    localparam int K_W          = (MAX_CHANNELS > 1) ? $clog2(2 * MAX_CHANNELS) : 1;

    localparam int DATA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int FMT_W    = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int NB_W     = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [FMT_W-1:0]     fmt_t;
    typedef logic [NB_W-1:0]      nbytes_t;
    typedef logic [DATA_W-1:0]    data_t;

    localparam cfg_idx_t REG_SAMPLE_FORMAT = 1'd0;
    localparam cfg_idx_t REG_CHANNEL_COUNT = 1'd1;

    localparam fmt_t FMT_NONE  = 4'd0;
    localparam fmt_t FMT_U8    = 4'd1;
    localparam fmt_t FMT_S16LE = 4'd2;
    localparam fmt_t FMT_U16LE = 4'd3;
    localparam fmt_t FMT_S24LE = 4'd4;
    localparam fmt_t FMT_U24LE = 4'd5;
    localparam fmt_t FMT_S32LE = 4'd6;
    localparam fmt_t FMT_U32LE = 4'd7;
    localparam fmt_t FMT_S16BE = 4'd8;
    localparam fmt_t FMT_U16BE = 4'd9;
    localparam fmt_t FMT_S24BE = 4'd10;
    localparam fmt_t FMT_U24BE = 4'd11;
    localparam fmt_t FMT_S32BE = 4'd12;
    localparam fmt_t FMT_U32BE = 4'd13;

    localparam logic [CFG_W-1:0] RESET_CHANNELS = 4'd2;

    // Bytes per sample; zero marks a format that never patches.
    function automatic nbytes_t fmt_bytes(fmt_t f);
        nbytes_t nb;
        case (f)
            FMT_U8: nb = 3'd1;
            FMT_S16LE, FMT_U16LE, FMT_S16BE, FMT_U16BE: nb = 3'd2;
            FMT_S24LE, FMT_U24LE, FMT_S24BE, FMT_U24BE: nb = 3'd3;
            FMT_S32LE, FMT_U32LE, FMT_S32BE, FMT_U32BE: nb = 3'd4;
            default: nb = 3'd0;
        endcase
        return nb;
    endfunction

    function automatic logic fmt_unsigned(fmt_t f);
        logic u;
        case (f)
            FMT_U8, FMT_U16LE, FMT_U24LE, FMT_U32LE,
            FMT_U16BE, FMT_U24BE, FMT_U32BE: u = 1'b1;
            default: u = 1'b0;
        endcase
        return u;
    endfunction

    function automatic logic fmt_big(fmt_t f);
        return (f >= FMT_S16BE) && (f <= FMT_U32BE);
    endfunction

    function automatic data_t width_mask(nbytes_t nb);
        data_t m;
        case (nb)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Reverses the low nb bytes of v for nb of 2 to 4 and clears the bytes above; other nb return v unchanged.
    function automatic data_t byte_swap(data_t v, nbytes_t nb);
        data_t r;
        case (nb)
            3'd2:    r = {16'h0000, v[7:0], v[15:8]};
            3'd3:    r = {8'h00, v[7:0], v[15:8], v[23:16]};
            3'd4:    r = {v[7:0], v[15:8], v[23:16], v[31:24]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic data_t silence_of(fmt_t f, nbytes_t nb);
        data_t s;
        if (!fmt_unsigned(f)) begin
            s = '0;
        end else begin
            case (nb)
                3'd1:    s = 32'h0000_0080;
                3'd2:    s = 32'h0000_8000;
                3'd3:    s = 32'h0080_0000;
                default: s = 32'h8000_0000;
            endcase
        end
        return s;
    endfunction

    function automatic data_t level_of(nbytes_t nb);
        data_t l;
        case (nb)
            3'd1:    l = 32'h0000_0001;
            3'd2:    l = 32'h0000_0010;
            3'd3:    l = 32'h0000_0100;
            default: l = 32'h0001_0000;
        endcase
        return l;
    endfunction

endpackage

// File: src/pcm_silence_keepalive_patcher.sv
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_sample_bytes, s_is_last
// m_       | out       | m_valid / m_ready  | m_patch_valid, m_patch_index,
//          |           |                    | m_patch_bytes, m_run_end
// cfg_     | in        | cfg_wen            | cfg_index, cfg_wdata
//
// A sample that is not last is taken in every cycle while no burst runs; its check is one compare per transfer.
// A last sample yields one result per cycle from a burst counter while m_ready does not stall,
// 2 * channels results when the buffer is patched and one result otherwise; input pauses
// until the final one of these moves into the output register.
// Reset is synchronous and active low; it restores the configuration and control registers and empties the output.
// A stall on m_ready holds the output register and, during a burst, the input.
module pcm_silence_keepalive_patcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  pskp_pkg::cfg_idx_t            cfg_index,
    input  logic [pskp_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pskp_pkg::DATA_W-1:0]   s_sample_bytes,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_patch_valid,
    output logic [pskp_pkg::IDX_W-1:0]    m_patch_index,
    output logic [pskp_pkg::DATA_W-1:0]   m_patch_bytes,
    output logic                          m_run_end
);
    import pskp_pkg::*;

    fmt_t              format_reg;
    logic [CFG_W-1:0]  channels_reg;
    logic              all_silent_reg, all_silent_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;

    logic              burst_active_reg, burst_active_next;
    logic              burst_patch_reg, burst_patch_next;
    logic [K_W-1:0]    burst_k_reg, burst_k_next;
    logic [K_W-1:0]    burst_last_reg, burst_last_next;
    logic [CH_W-1:0]   burst_ch_reg, burst_ch_next;
    data_t             pos_reg, pos_next;
    data_t             neg_reg, neg_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_patch_valid_reg, m_patch_valid_next;
    logic [IDX_W-1:0]  m_patch_index_reg, m_patch_index_next;
    data_t             m_patch_bytes_reg, m_patch_bytes_next;
    logic              m_run_end_reg, m_run_end_next;

    nbytes_t           nb;
    logic              big;
    data_t             mask, raw, val, sil, lvl;
    logic              sample_silent, silent_now, do_patch;
    logic [CH_W-1:0]   ch_eff;
    logic [SEEN_W-1:0] two_frames, seen_now;
    logic              s_fire, out_load, burst_done;

    always_comb begin
        nb   = fmt_bytes(format_reg);
        big  = fmt_big(format_reg);
        mask = width_mask(nb);
        sil  = silence_of(format_reg, nb);
        lvl  = level_of(nb);
        raw  = s_sample_bytes & mask;
        val  = big ? byte_swap(raw, nb) : raw;
        sample_silent = (nb != '0) && (val == sil);

        if (channels_reg == '0) begin
            ch_eff = CH_W'(1);
        end else if (int'(channels_reg) > MAX_CHANNELS) begin
            ch_eff = CH_W'(MAX_CHANNELS);
        end else begin
            ch_eff = CH_W'(channels_reg);
        end
        two_frames = SEEN_W'({ch_eff, 1'b0});
        seen_now   = (seen_reg < two_frames) ? seen_reg + SEEN_W'(1) : two_frames;
        silent_now = all_silent_reg && sample_silent;
        do_patch   = (nb != '0) && silent_now && (seen_now >= two_frames);
    end

    assign out_load   = burst_active_reg && (!m_valid_reg || m_ready);
    assign burst_done = out_load && (burst_k_reg == burst_last_reg);
    assign s_ready    = !burst_active_reg || burst_done;
    assign s_fire     = s_valid && s_ready;

    always_comb begin
        all_silent_next    = all_silent_reg;
        seen_next          = seen_reg;
        burst_active_next  = burst_active_reg;
        burst_patch_next   = burst_patch_reg;
        burst_k_next       = burst_k_reg;
        burst_last_next    = burst_last_reg;
        burst_ch_next      = burst_ch_reg;
        pos_next           = pos_reg;
        neg_next           = neg_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_patch_valid_next = m_patch_valid_reg;
        m_patch_index_next = m_patch_index_reg;
        m_patch_bytes_next = m_patch_bytes_reg;
        m_run_end_next     = m_run_end_reg;

        if (out_load) begin
            m_valid_next       = 1'b1;
            m_patch_valid_next = burst_patch_reg;
            m_patch_index_next = burst_patch_reg ? IDX_W'(burst_k_reg) : '0;
            if (!burst_patch_reg) begin
                m_patch_bytes_next = '0;
            end else if (SEEN_W'(burst_k_reg) < SEEN_W'(burst_ch_reg)) begin
                m_patch_bytes_next = pos_reg;
            end else begin
                m_patch_bytes_next = neg_reg;
            end
            m_run_end_next = burst_done;
            burst_k_next   = burst_k_reg + K_W'(1);
            if (burst_done) begin
                burst_active_next = 1'b0;
            end
        end

        if (s_fire) begin
            if (s_is_last) begin
                all_silent_next   = 1'b1;
                seen_next         = '0;
                burst_active_next = 1'b1;
                burst_patch_next  = do_patch;
                burst_k_next      = '0;
                burst_last_next   = do_patch ? K_W'(two_frames - SEEN_W'(1)) : '0;
                burst_ch_next     = ch_eff;
                pos_next = big ? byte_swap((sil + lvl) & mask, nb) : ((sil + lvl) & mask);
                neg_next = big ? byte_swap((sil - lvl) & mask, nb) : ((sil - lvl) & mask);
            end else begin
                all_silent_next = silent_now;
                seen_next       = seen_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg       <= FMT_NONE;
            channels_reg     <= RESET_CHANNELS;
            all_silent_reg   <= 1'b1;
            seen_reg         <= '0;
            burst_active_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_SAMPLE_FORMAT: format_reg   <= cfg_wdata;
                    REG_CHANNEL_COUNT: channels_reg <= cfg_wdata;
                endcase
            end
            all_silent_reg   <= all_silent_next;
            seen_reg         <= seen_next;
            burst_active_reg <= burst_active_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        burst_patch_reg   <= burst_patch_next;
        burst_k_reg       <= burst_k_next;
        burst_last_reg    <= burst_last_next;
        burst_ch_reg      <= burst_ch_next;
        pos_reg           <= pos_next;
        neg_reg           <= neg_next;
        m_patch_valid_reg <= m_patch_valid_next;
        m_patch_index_reg <= m_patch_index_next;
        m_patch_bytes_reg <= m_patch_bytes_next;
        m_run_end_reg     <= m_run_end_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_patch_valid = m_patch_valid_reg;
    assign m_patch_index = m_patch_index_reg;
    assign m_patch_bytes = m_patch_bytes_reg;
    assign m_run_end     = m_run_end_reg;

endmodule

// File: src/pskp_checker.sv
`include "pcm_silence_keepalive_patcher_macros.svh"

module pskp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wen,
    input pskp_pkg::cfg_idx_t            cfg_index,
    input logic [pskp_pkg::CFG_W-1:0]    cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [pskp_pkg::DATA_W-1:0]   s_sample_bytes,
    input logic                          s_is_last,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_patch_valid,
    input logic [pskp_pkg::IDX_W-1:0]    m_patch_index,
    input logic [pskp_pkg::DATA_W-1:0]   m_patch_bytes,
    input logic                          m_run_end
);
    import pskp_pkg::*;

    // A stalled result keeps its payload.
    `PSKP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_patch_bytes) && $stable(m_patch_index) && $stable(m_run_end))

    // A buffer that is not patched gives a single all-zero result that closes the run.
    `PSKP_ASSERT_SAME(a_no_patch_shape, aclk, aresetn, m_valid && !m_patch_valid, m_run_end && (m_patch_index == '0) && (m_patch_bytes == '0))

    // Within a patch burst the next write follows at once at the next index.
    `PSKP_ASSERT_NEXT(a_burst_step, aclk, aresetn, m_valid && m_ready && m_patch_valid && !m_run_end, m_valid && m_patch_valid && (m_patch_index == IDX_W'($past(m_patch_index) + IDX_W'(1))))

    // Two full frames always end on an odd index.
    `PSKP_ASSERT_SAME(a_burst_end_odd, aclk, aresetn, m_valid && m_patch_valid && m_run_end, m_patch_index[0])

endmodule

bind pcm_silence_keepalive_patcher pskp_checker u_pskp_checker (.*);
